### rtl/assert_macros.svh
// assertion helpers for the rtl files, included by sete_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define SETE_ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define SETE_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define SETE_ASSERT_PROP(label, clk, rst_n, prop)
`define SETE_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### rtl/sete_pkg.sv
// ----------------------------------------------------------------------------
// sete_pkg
// Types and constants shared by the sprite entry tile expander modules.
// ----------------------------------------------------------------------------
package sete_pkg;

    localparam int ATTR_EN_BIT    = 15;
    localparam int ATTR_FX_BIT    = 14;
    localparam int ATTR_FY_BIT    = 13;
    localparam int COORD_SIGN_BIT = 15;
    localparam int POS_W          = 11;

    localparam logic [6:0] PALETTE_BASE = 7'd64;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic last;
    } t_status;

endpackage

### rtl/sete_ctrl.sv
// ----------------------------------------------------------------------------
// sete_ctrl
// Handshake controller: takes an entry, then walks its placements out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sete_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sete_pkg::t_status i_status,
    output sete_pkg::t_cmd    o_cmd
);
    import sete_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_status.match) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SETE_ASSERT_PROP(a_hold_stall, i_clk, i_rst_n, (r_state == ST_RUN && !i_out_ready) |=> (r_state == ST_RUN))
    `SETE_ASSERT_PROP(a_step_not_last, i_clk, i_rst_n, o_cmd.step |-> (r_state == ST_RUN && !i_status.last))
    `SETE_ASSERT_PROP(a_idle_after_last, i_clk, i_rst_n, (o_out_valid && i_out_ready && i_status.last) |=> o_in_ready)
    `SETE_ASSERT_NEVER(a_load_while_busy, i_clk, i_rst_n, o_cmd.load && r_state == ST_RUN)

endmodule

### rtl/sete_dp.sv
// ----------------------------------------------------------------------------
// sete_dp
// Datapath: entry decode, priority register and cell walk counters.
// ----------------------------------------------------------------------------
module sete_dp #(
    parameter int TILE_PIXELS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_data,
    input  logic [15:0]              i_attr_word,
    input  logic [15:0]              i_tile_word,
    input  logic [15:0]              i_x_word,
    input  logic [15:0]              i_y_word,
    input  sete_pkg::t_cmd           i_cmd,
    output sete_pkg::t_status        o_status,
    output logic [13:0]              o_tile_code,
    output logic [6:0]               o_palette_color,
    output logic                     o_mirror_x,
    output logic                     o_mirror_y,
    output logic signed [10:0]       o_x_pos,
    output logic signed [10:0]       o_y_pos,
    output logic                     o_last
);
    import sete_pkg::*;

    localparam logic [POS_W-1:0] STEP = POS_W'(TILE_PIXELS);

    logic [1:0]       r_prio;
    logic [13:0]      r_tile;
    logic [6:0]       r_color;
    logic             r_fx;
    logic             r_fy;
    logic [POS_W-1:0] r_x;
    logic [POS_W-1:0] r_y;
    logic [POS_W-1:0] r_y0;
    logic [2:0]       r_col;
    logic [2:0]       r_row;
    logic [2:0]       r_cols_m1;
    logic [2:0]       r_rows_m1;

    logic [2:0]       w_cols_m1;
    logic [POS_W-1:0] w_x0;
    logic [POS_W-1:0] w_y0;
    logic [POS_W-1:0] w_xoff;

    assign w_cols_m1 = i_attr_word[12:10];
    assign w_x0 = {{2{i_x_word[COORD_SIGN_BIT]}}, i_x_word[8:0]};
    assign w_y0 = {{2{i_y_word[COORD_SIGN_BIT]}}, i_y_word[8:0]};
    assign w_xoff = i_attr_word[ATTR_FX_BIT]
                  ? POS_W'({{(POS_W-3){1'b0}}, w_cols_m1} * STEP) : '0;

    assign o_status.match = i_attr_word[ATTR_EN_BIT] && (i_tile_word[15:14] == r_prio);
    assign o_status.last  = (r_col == r_cols_m1) && (r_row == r_rows_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= '0;
        end else if (i_cfg_we) begin
            r_prio <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tile    <= i_tile_word[13:0];
            r_color   <= 7'(i_attr_word[5:0]) + PALETTE_BASE;
            r_fx      <= i_attr_word[ATTR_FX_BIT];
            r_fy      <= i_attr_word[ATTR_FY_BIT];
            r_x       <= w_x0 + w_xoff;
            r_y       <= w_y0;
            r_y0      <= w_y0;
            r_col     <= '0;
            r_row     <= '0;
            r_cols_m1 <= w_cols_m1;
            r_rows_m1 <= i_attr_word[9:7];
        end else if (i_cmd.step) begin
            r_tile <= r_tile + 14'd1;
            if (r_row == r_rows_m1) begin
                r_row <= '0;
                r_col <= r_col + 3'd1;
                r_y   <= r_y0;
                r_x   <= r_fx ? (r_x - STEP) : (r_x + STEP);
            end else begin
                r_row <= r_row + 3'd1;
                r_y   <= r_y + STEP;
            end
        end
    end

    assign o_tile_code     = r_tile;
    assign o_palette_color = r_color;
    assign o_mirror_x      = r_fx;
    assign o_mirror_y      = r_fy;
    assign o_x_pos         = r_x;
    assign o_y_pos         = r_y;
    assign o_last          = o_status.last;

endmodule

### rtl/sprite_entry_tile_expander.sv
// ----------------------------------------------------------------------------
// sprite_entry_tile_expander
// Expands one sprite list entry into a column-major run of tile placements.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_ready carry one four-word entry
//   output channel: o_out_valid / i_out_ready carry one tile placement
//   config: i_cfg_we writes the 2-bit priority class from i_cfg_data
//   an entry that is disabled or of another priority is dropped on transfer
//   a kept entry shows its first placement in the cycle after the transfer,
//   then one placement per cycle while the receiver takes them
//   a dropped entry leaves the block idle; one entry is in flight at a
//   time, and no new entry is taken until its last placement is taken
//   o_last marks the final placement; the next entry is taken after it
//   a stalled receiver holds the current placement unchanged
//   synchronous reset returns to idle and clears the priority class to 0
// ----------------------------------------------------------------------------
module sprite_entry_tile_expander #(
    parameter int TILE_PIXELS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_attr_word,
    input  logic [15:0]        i_tile_word,
    input  logic [15:0]        i_x_word,
    input  logic [15:0]        i_y_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [13:0]        o_tile_code,
    output logic [6:0]         o_palette_color,
    output logic               o_mirror_x,
    output logic               o_mirror_y,
    output logic signed [10:0] o_x_pos,
    output logic signed [10:0] o_y_pos,
    output logic               o_last
);
    import sete_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    sete_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sete_dp #(
        .TILE_PIXELS (TILE_PIXELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_attr_word     (i_attr_word),
        .i_tile_word     (i_tile_word),
        .i_x_word        (i_x_word),
        .i_y_word        (i_y_word),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_tile_code     (o_tile_code),
        .o_palette_color (o_palette_color),
        .o_mirror_x      (o_mirror_x),
        .o_mirror_y      (o_mirror_y),
        .o_x_pos         (o_x_pos),
        .o_y_pos         (o_y_pos),
        .o_last          (o_last)
    );

endmodule
